FILE: design/matrix_inverse_3x3_defines.svh
// Assertion macros shared by the matrix inverse design files.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MI3_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("matrix inverse check failed");
// Condition that must be followed by another in the next cycle.
`define MI3_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("matrix inverse sequence check failed");
`else
`define MI3_ASSERT(name, prop)
`define MI3_ASSERT_NEXT(name, pre, post)
`endif
`endif

FILE: design/mi3_pkg.sv
// Shared constants and the result saturation function of the matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

  // Result format is signed Q16.16 in 32 bits.
  localparam int OUT_WIDTH = 32;
  localparam int OUT_FRAC  = 16;
  // Quotient bits kept by the divider; anything larger saturates.
  localparam int QUOT_BITS = 33;

  localparam logic [OUT_WIDTH-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_WIDTH-1:0] MAX_NEG = 32'h8000_0000;

  // Applies sign, saturation and the singular case to a quotient magnitude.
  function automatic logic [OUT_WIDTH-1:0] sat_result(logic [QUOT_BITS-1:0] q, logic neg,
                                                      logic ovf, logic zero);
    logic [OUT_WIDTH-1:0] r;
    if (zero) begin
      r = '0;
    end else if (!neg) begin
      r = (ovf || q > {1'b0, MAX_POS}) ? MAX_POS : q[OUT_WIDTH-1:0];
    end else begin
      r = (ovf || q > {1'b0, MAX_NEG}) ? MAX_NEG : (~q[OUT_WIDTH-1:0]) + 32'd1;
    end
    return r;
  endfunction

endpackage

FILE: design/mi3_cofactor.sv
// Four-stage pipeline computing the nine cofactors and the determinant.
`timescale 1ns / 1ps
module mi3_cofactor #(
  parameter int EW = 16,
  parameter int CW = 2 * EW + 1,
  parameter int DW = 3 * EW + 3
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [EW-1:0] a_i   [9],
  output logic signed [CW-1:0] cof_o [9],
  output logic signed [DW-1:0] det_o
);

  // Operand indexes of the two products that form each cofactor.
  localparam int P1A [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int P1B [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int P2A [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int P2B [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  logic signed [2*EW-1:0]  p1_q  [9];
  logic signed [2*EW-1:0]  p2_q  [9];
  logic signed [EW-1:0]    r0a_q [3];
  logic signed [EW-1:0]    r0b_q [3];
  logic signed [CW-1:0]    cofb_q [9];
  logic signed [CW-1:0]    cofc_q [9];
  logic signed [CW-1:0]    cofd_q [9];
  logic signed [EW+CW-1:0] dp_q  [3];
  logic signed [DW-1:0]    det_q;

  // Products, cofactor differences, first-row products, determinant sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        p1_q[i]   <= a_i[P1A[i]] * a_i[P1B[i]];
        p2_q[i]   <= a_i[P2A[i]] * a_i[P2B[i]];
        cofb_q[i] <= CW'(p1_q[i]) - CW'(p2_q[i]);
        cofc_q[i] <= cofb_q[i];
        cofd_q[i] <= cofc_q[i];
      end
      for (int j = 0; j < 3; j++) begin
        r0a_q[j] <= a_i[j];
        r0b_q[j] <= r0a_q[j];
        dp_q[j]  <= r0b_q[j] * cofb_q[j];
      end
      det_q <= DW'(dp_q[0]) + DW'(dp_q[1]) + DW'(dp_q[2]);
    end
  end

  assign cof_o = cofd_q;
  assign det_o = det_q;

endmodule

FILE: design/mi3_div_lane.sv
// Pipelined restoring divider: one quotient bit per stage, saturated result.
`timescale 1ns / 1ps
module mi3_div_lane #(
  parameter int CW = 33,
  parameter int DW = 51,
  parameter int FB = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] cof_i,
  input  logic signed [DW-1:0] det_i,
  output logic [31:0]          res_o
);
  import mi3_pkg::*;

  localparam int NW = CW + FB + OUT_FRAC;
  localparam int RW = (NW > DW + QUOT_BITS) ? NW : DW + QUOT_BITS;

  logic [CW-1:0]        cmag;
  logic [DW-1:0]        dmag;
  logic [RW-1:0]        num;
  logic [RW-1:0]        rem_q  [QUOT_BITS+1];
  logic [DW-1:0]        d_q    [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q_q    [QUOT_BITS+1];
  logic                 neg_q  [QUOT_BITS+1];
  logic                 ovf_q  [QUOT_BITS+1];
  logic                 zero_q [QUOT_BITS+1];
  logic [RW-1:0]        dsh    [QUOT_BITS];
  logic                 ge     [QUOT_BITS];
  logic [OUT_WIDTH-1:0] res_q;

  // Magnitudes of the operands; the numerator is scaled to Q16.16.
  always_comb begin
    cmag = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
    dmag = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
    num  = RW'(cmag) << (FB + OUT_FRAC);
  end

  // Each stage tries the divisor shifted to its quotient bit.
  always_comb begin
    for (int k = 0; k < QUOT_BITS; k++) begin
      dsh[k] = RW'(d_q[k]) << (QUOT_BITS - 1 - k);
      ge[k]  = rem_q[k] >= dsh[k];
    end
  end

  // Entry stage, the bit stages and the output register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num;
      d_q[0]    <= dmag;
      q_q[0]    <= '0;
      neg_q[0]  <= cof_i[CW-1] ^ det_i[DW-1];
      ovf_q[0]  <= num >= (RW'(dmag) << QUOT_BITS);
      zero_q[0] <= det_i == '0;
      for (int k = 0; k < QUOT_BITS; k++) begin
        rem_q[k+1]  <= ge[k] ? rem_q[k] - dsh[k] : rem_q[k];
        q_q[k+1]    <= {q_q[k][QUOT_BITS-2:0], ge[k]};
        d_q[k+1]    <= d_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        zero_q[k+1] <= zero_q[k];
      end
      res_q <= sat_result(q_q[QUOT_BITS], neg_q[QUOT_BITS], ovf_q[QUOT_BITS],
                          zero_q[QUOT_BITS]);
    end
  end

  assign res_o = res_q;

endmodule

FILE: design/matrix_inverse_3x3.sv
// Top level of the pipelined 3x3 matrix inverse.
`timescale 1ns / 1ps
`include "matrix_inverse_3x3_defines.svh"
// Usage:
// The slave stream carries one matrix per beat: nine signed elements of
// ELEMENT_WIDTH bits with FRACTION_BITS fraction bits, row-major, m00 lowest.
// The master stream returns one beat per matrix: nine signed Q16.16 inverse
// entries, row-major, inv00 lowest, truncated toward zero and saturated.
// tuser is the singular flag; when it is set all entries are zero.
// An accepted beat reaches its result beat through the cofactor and
// determinant arithmetic, one divider entry stage, 33 quotient bit
// stages and the output register.
// Throughput is one matrix per cycle while results are taken; the quotient
// stage chain sets the latency and each stage holds one matrix per lane.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and tready drops; nothing is lost or repeated, and it resumes on the
// next cycle that the result is taken.
// Reset clears the valid bits only, so the block comes up empty and ready.
module matrix_inverse_3x3 #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // Fields from bit 0: m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill.
  input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // Fields from bit 0: inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22.
  output logic [9*mi3_pkg::OUT_WIDTH-1:0] m_axis_tdata_o,
  // Fields from bit 0: singular.
  output logic m_axis_tuser_o
);
  import mi3_pkg::*;

  localparam int EW  = ELEMENT_WIDTH;
  localparam int CW  = 2 * EW + 1;
  localparam int DW  = 3 * EW + 3;
  localparam int DIV_LAT = QUOT_BITS + 2;
  localparam int LAT = 4 + DIV_LAT;

  logic                 pipe_en;
  logic [LAT-1:0]       vld_q;
  logic [DIV_LAT-1:0]   sing_q;
  logic signed [EW-1:0] elem [9];
  logic signed [CW-1:0] cof  [9];
  logic signed [DW-1:0] det;
  logic [OUT_WIDTH-1:0] res  [9];

  // The pipeline moves whenever the output register is empty or taken.
  assign pipe_en         = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;
  assign m_axis_tvalid_o = vld_q[LAT-1];
  assign m_axis_tuser_o  = sing_q[DIV_LAT-1];

  // Unpack the input beat into elements.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      elem[i] = s_axis_tdata_i[i*EW +: EW];
    end
  end

  // Valid bits that travel beside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  // Singular flag follows the divider latency.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sing_q <= {sing_q[DIV_LAT-2:0], det == '0};
    end
  end

  mi3_cofactor #(
    .EW(EW),
    .CW(CW),
    .DW(DW)
  ) u_cofactor (
    .clk_i(clk_i),
    .en_i (pipe_en),
    .a_i  (elem),
    .cof_o(cof),
    .det_o(det)
  );

  // Inverse entry (r,c) divides cofactor (c,r) by the determinant.
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      mi3_div_lane #(
        .CW(CW),
        .DW(DW),
        .FB(FRACTION_BITS)
      ) u_lane (
        .clk_i(clk_i),
        .en_i (pipe_en),
        .cof_i(cof[c*3+r]),
        .det_i(det),
        .res_o(res[r*3+c])
      );
      assign m_axis_tdata_o[(r*3+c)*OUT_WIDTH +: OUT_WIDTH] = res[r*3+c];
    end
  end

  `MI3_ASSERT(a_singular_zero, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
  `MI3_ASSERT(a_stall_holds, !pipe_en |=> $stable(vld_q))
  `MI3_ASSERT_NEXT(a_accept_enters, s_axis_tvalid_i && s_axis_tready_o, vld_q[0])

endmodule
